### hdl/pds_pkg.sv
// shared constants and types for the pll divider search block
package pds_pkg;

    // field widths
    localparam int FREQ_W = 10;
    localparam int XTAL_W = 5;
    localparam int M_W    = 6;
    localparam int N_W    = 9;
    localparam int P_W    = 4;
    localparam int Q_W    = 4;
    localparam int PROD_W = 14;
    localparam int VCO_W  = 15;

    // shared divider geometry
    localparam int DIV_W   = 10;
    localparam int DCNT_W  = 4;
    localparam logic [DCNT_W-1:0] DIV_LAST = 4'd9;

    // clock plan constants
    localparam logic [DIV_W-1:0]  USB_MHZ    = 10'd48;
    localparam logic [DIV_W-1:0]  VCO_N_MIN  = 10'd192;
    localparam logic [VCO_W-1:0]  VCO_N_MAX  = 15'd432;
    localparam logic [PROD_W-1:0] PROD_MIN   = 14'd96;   // q of 2
    localparam logic [PROD_W-1:0] PROD_MAX   = 14'd720;  // q of 15
    localparam logic [XTAL_W-1:0] XTAL_RESET = 5'd8;
    localparam logic [1:0]        P_LAST     = 2'd3;     // post-divider 8

    // sequencer states
    typedef enum logic [10:0] {
        ST_IDLE = 11'b000_0000_0001,
        ST_CAND = 11'b000_0000_0010,
        ST_DQ   = 11'b000_0000_0100,
        ST_CQ   = 11'b000_0000_1000,
        ST_DR   = 11'b000_0001_0000,
        ST_CR   = 11'b000_0010_0000,
        ST_DM   = 11'b000_0100_0000,
        ST_CM   = 11'b000_1000_0000,
        ST_MN   = 11'b001_0000_0000,
        ST_CN   = 11'b010_0000_0000,
        ST_FIN  = 11'b100_0000_0000
    } t_state;

endpackage

### hdl/pll_divider_search.sv
// pll divider search: sequencer around one shared 10-step restoring divider
// throughput: one item at a time, o_ready is high only while the sequencer idles
// a finished result waits in the output register while the next item is taken
// reset: crystal register returns to 8 MHz, sequencer idle, no result pending
module pll_divider_search (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [pds_pkg::XTAL_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [pds_pkg::FREQ_W-1:0]  i_wanted_mhz,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_found,
    output logic [pds_pkg::FREQ_W-1:0]  o_achieved_mhz,
    output logic [pds_pkg::M_W-1:0]     o_pll_m,
    output logic [pds_pkg::N_W-1:0]     o_pll_n,
    output logic [pds_pkg::P_W-1:0]     o_pll_p,
    output logic [pds_pkg::Q_W-1:0]     o_pll_q
);

    pds_pkg::t_state r_state, n_state;

    logic [pds_pkg::XTAL_W-1:0] r_xtal;
    logic [pds_pkg::FREQ_W-1:0] r_f, n_f;
    logic [1:0]                 r_pidx, n_pidx;
    logic [pds_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [pds_pkg::Q_W-1:0]    r_q, n_q;
    logic [pds_pkg::DIV_W-1:0]  r_r, n_r;
    logic [pds_pkg::XTAL_W-1:0] r_m, n_m;
    logic [pds_pkg::VCO_W-1:0]  r_n, n_n;
    logic                       r_found, n_found;

    logic [pds_pkg::DIV_W-1:0]  r_dq, n_dq;
    logic [pds_pkg::DIV_W-1:0]  r_drem, n_drem;
    logic [pds_pkg::DIV_W-1:0]  r_dvs, n_dvs;
    logic [pds_pkg::DCNT_W-1:0] r_dcnt, n_dcnt;

    logic                       r_o_valid, n_o_valid;
    logic                       r_o_found, n_o_found;
    logic [pds_pkg::FREQ_W-1:0] r_o_f, n_o_f;
    logic [pds_pkg::M_W-1:0]    r_o_m, n_o_m;
    logic [pds_pkg::N_W-1:0]    r_o_n, n_o_n;
    logic [pds_pkg::P_W-1:0]    r_o_p, n_o_p;
    logic [pds_pkg::Q_W-1:0]    r_o_q, n_o_q;

    // shared divider step
    logic [pds_pkg::DIV_W:0]    w_trial;
    logic                       w_ge;
    logic [pds_pkg::DIV_W:0]    w_diff;
    logic [pds_pkg::DIV_W-1:0]  w_step_rem;
    logic [pds_pkg::DIV_W-1:0]  w_step_q;

    assign w_trial    = {r_drem, r_dq[pds_pkg::DIV_W-1]};
    assign w_ge       = (w_trial >= {1'b0, r_dvs});
    assign w_diff     = w_trial - {1'b0, r_dvs};
    assign w_step_rem = w_ge ? w_diff[pds_pkg::DIV_W-1:0] : w_trial[pds_pkg::DIV_W-1:0];
    assign w_step_q   = {r_dq[pds_pkg::DIV_W-2:0], w_ge};

    // candidate product and m bound
    logic [pds_pkg::P_W-1:0]    w_pval;
    logic [pds_pkg::PROD_W-1:0] w_prod;
    logic [pds_pkg::DIV_W:0]    w_ceil;
    logic [pds_pkg::DIV_W:0]    w_half;
    logic [pds_pkg::DIV_W:0]    w_mval;

    assign w_pval = {1'b0, r_pidx, 1'b0} + 4'd2;
    assign w_prod = pds_pkg::PROD_W'(r_f) * pds_pkg::PROD_W'(w_pval);
    assign w_ceil = {1'b0, r_dq} + {{pds_pkg::DIV_W{1'b0}}, (r_drem != '0)};
    assign w_half = (pds_pkg::DIV_W+1)'(r_xtal >> 1);
    assign w_mval = (w_ceil > w_half) ? w_ceil : w_half;

    // sequencer
    always_comb begin
        logic adv;
        adv       = 1'b0;
        n_state   = r_state;
        n_f       = r_f;
        n_pidx    = r_pidx;
        n_prod    = r_prod;
        n_q       = r_q;
        n_r       = r_r;
        n_m       = r_m;
        n_n       = r_n;
        n_found   = r_found;
        n_dq      = r_dq;
        n_drem    = r_drem;
        n_dvs     = r_dvs;
        n_dcnt    = r_dcnt;
        n_o_valid = r_o_valid;
        n_o_found = r_o_found;
        n_o_f     = r_o_f;
        n_o_m     = r_o_m;
        n_o_n     = r_o_n;
        n_o_p     = r_o_p;
        n_o_q     = r_o_q;

        // result taken downstream
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            pds_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_f     = i_wanted_mhz;
                    n_pidx  = 2'd0;
                    n_found = 1'b0;
                    if (i_wanted_mhz == '0 || r_xtal == '0) begin
                        n_state = pds_pkg::ST_FIN;
                    end else begin
                        n_state = pds_pkg::ST_CAND;
                    end
                end
            end
            // cheap rejects: q out of range or product not a multiple of 16
            pds_pkg::ST_CAND: begin
                n_prod = w_prod;
                if (w_prod >= pds_pkg::PROD_MIN && w_prod <= pds_pkg::PROD_MAX &&
                    w_prod[3:0] == 4'd0) begin
                    n_dq    = w_prod[pds_pkg::DIV_W-1:0];
                    n_drem  = '0;
                    n_dvs   = pds_pkg::USB_MHZ;
                    n_dcnt  = '0;
                    n_state = pds_pkg::ST_DQ;
                end else begin
                    adv = 1'b1;
                end
            end
            pds_pkg::ST_DQ, pds_pkg::ST_DR, pds_pkg::ST_DM: begin
                n_dq   = w_step_q;
                n_drem = w_step_rem;
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == pds_pkg::DIV_LAST) begin
                    if (r_state == pds_pkg::ST_DQ) begin
                        n_state = pds_pkg::ST_CQ;
                    end else if (r_state == pds_pkg::ST_DR) begin
                        n_state = pds_pkg::ST_CR;
                    end else begin
                        n_state = pds_pkg::ST_CM;
                    end
                end
            end
            // usb divide exact, then divide by the crystal
            pds_pkg::ST_CQ: begin
                if (r_drem == '0) begin
                    n_q     = r_dq[pds_pkg::Q_W-1:0];
                    n_dq    = r_prod[pds_pkg::DIV_W-1:0];
                    n_drem  = '0;
                    n_dvs   = pds_pkg::DIV_W'(r_xtal);
                    n_dcnt  = '0;
                    n_state = pds_pkg::ST_DR;
                end else begin
                    adv = 1'b1;
                end
            end
            // crystal divide exact, then 192 over the ratio
            pds_pkg::ST_CR: begin
                if (r_drem == '0) begin
                    n_r     = r_dq;
                    n_dq    = pds_pkg::VCO_N_MIN;
                    n_drem  = '0;
                    n_dvs   = r_dq;
                    n_dcnt  = '0;
                    n_state = pds_pkg::ST_DM;
                end else begin
                    adv = 1'b1;
                end
            end
            // m is the larger of half the crystal and the rounded-up quotient; rejected if above the crystal
            pds_pkg::ST_CM: begin
                if (w_mval > (pds_pkg::DIV_W+1)'(r_xtal)) begin
                    adv = 1'b1;
                end else begin
                    n_m     = w_mval[pds_pkg::XTAL_W-1:0];
                    n_state = pds_pkg::ST_MN;
                end
            end
            pds_pkg::ST_MN: begin
                n_n     = pds_pkg::VCO_W'(r_r) * pds_pkg::VCO_W'(r_m);
                n_state = pds_pkg::ST_CN;
            end
            pds_pkg::ST_CN: begin
                if (r_n <= pds_pkg::VCO_N_MAX) begin
                    n_found = 1'b1;
                    n_state = pds_pkg::ST_FIN;
                end else begin
                    adv = 1'b1;
                end
            end
            // hand the item over once the output register is free
            pds_pkg::ST_FIN: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_found = r_found;
                    n_o_f     = r_found ? r_f : '0;
                    n_o_m     = r_found ? pds_pkg::M_W'(r_m) : '0;
                    n_o_n     = r_found ? r_n[pds_pkg::N_W-1:0] : '0;
                    n_o_p     = r_found ? w_pval : '0;
                    n_o_q     = r_found ? r_q : '0;
                    n_state   = pds_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pds_pkg::ST_IDLE;
            end
        endcase

        // step to the next post-divider, then the next lower frequency; not found after 1 MHz
        if (adv) begin
            if (r_pidx == pds_pkg::P_LAST) begin
                if (r_f == 10'd1) begin
                    n_found = 1'b0;
                    n_state = pds_pkg::ST_FIN;
                end else begin
                    n_f     = r_f - 1'b1;
                    n_pidx  = 2'd0;
                    n_state = pds_pkg::ST_CAND;
                end
            end else begin
                n_pidx  = r_pidx + 1'b1;
                n_state = pds_pkg::ST_CAND;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pds_pkg::ST_IDLE;
            r_o_valid <= 1'b0;
            r_xtal    <= pds_pkg::XTAL_RESET;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (i_cfg_we) begin
                r_xtal <= i_cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_f       <= n_f;
        r_pidx    <= n_pidx;
        r_prod    <= n_prod;
        r_q       <= n_q;
        r_r       <= n_r;
        r_m       <= n_m;
        r_n       <= n_n;
        r_found   <= n_found;
        r_dq      <= n_dq;
        r_drem    <= n_drem;
        r_dvs     <= n_dvs;
        r_dcnt    <= n_dcnt;
        r_o_found <= n_o_found;
        r_o_f     <= n_o_f;
        r_o_m     <= n_o_m;
        r_o_n     <= n_o_n;
        r_o_p     <= n_o_p;
        r_o_q     <= n_o_q;
    end

    assign o_ready        = (r_state == pds_pkg::ST_IDLE);
    assign o_valid        = r_o_valid;
    assign o_found        = r_o_found;
    assign o_achieved_mhz = r_o_f;
    assign o_pll_m        = r_o_m;
    assign o_pll_n        = r_o_n;
    assign o_pll_p        = r_o_p;
    assign o_pll_q        = r_o_q;

    // a found setting keeps the vco multiplier in range
    a_n_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_pll_n >= 9'd192 && o_pll_n <= 9'd432))
        else $error("pll_n out of range");

    // a found setting has a legal post-divider and usb divider
    a_pq_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> ((o_pll_p == 4'd2 || o_pll_p == 4'd4 ||
        o_pll_p == 4'd6 || o_pll_p == 4'd8) && o_pll_q >= 4'd2))
        else $error("illegal pll_p or pll_q");

    // not found reports all fields as zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_achieved_mhz == '0 && o_pll_m == '0 &&
        o_pll_n == '0 && o_pll_p == '0 && o_pll_q == '0))
        else $error("not found result carries nonzero fields");

    // accepting an item starts the search
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("ready after accepting an item");

    // the divider never runs past its last step
    a_div_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pds_pkg::ST_DQ || r_state == pds_pkg::ST_DR ||
        r_state == pds_pkg::ST_DM) |-> (r_dcnt <= pds_pkg::DIV_LAST))
        else $error("divider step count overrun");

endmodule
